// ===== hdl/ufsf_pkg.sv =====
// Package with payload types and codes for the union-find spanning forest block.
package ufsf_pkg;

    localparam int NODE_W = 10;
    localparam int CNT_W = 11;
    localparam int WGT_W = 32;
    localparam int SUM_W = 64;

    localparam logic [1:0] ST_MERGED = 2'd0;
    localparam logic [1:0] ST_SAME   = 2'd1;
    localparam logic [1:0] ST_LATE   = 2'd2;
    localparam logic [1:0] ST_RANGE  = 2'd3;

    localparam logic CFG_NODE_COUNT = 1'b0;
    localparam logic CFG_DIVISOR    = 1'b1;

    typedef struct packed {
        logic              mode;
        logic [NODE_W-1:0] node_a;
        logic [NODE_W-1:0] node_b;
        logic signed [WGT_W-1:0] edge_weight;
    } in_item_t;

    typedef struct packed {
        logic [1:0]              status;
        logic signed [SUM_W-1:0] total_sum;
        logic                    is_total;
    } out_item_t;

endpackage

// ===== hdl/union_find_spanning_forest.sv =====
// Top level of the union-find spanning forest engine.
//
// The engine keeps parent links, group sizes and group weights for MAX_NODES nodes
// in single-port memories with registered reads, driven by a small sequencer.
// An edge item walks the find path of each endpoint, reading and then checking each
// node on the way, and walks each path again to compress it. Merging two groups
// reads both roots, writes the surviving root and links the smaller one, and the
// result is then presented. The single memory port is why each node visit is split
// into a read state and a check state.
// A finish item visits each node below node_count (at most MAX_NODES) in turn.
// Each visit has a read step, an iterative subtract-and-shift modulo unit of one
// load step plus one step per size bit (11 size bits for the default store), and
// an add step. The store is then cleared, and the total is presented as the clear
// ends. After reset the block runs the same clearing pass before it accepts items.
// in_stall is high whenever the sequencer is busy or a result waits.
module union_find_spanning_forest #(
    parameter int MAX_NODES = 1024
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_stall,
    input  ufsf_pkg::in_item_t   in_item,
    output logic                 out_valid,
    input  logic                 out_stall,
    output ufsf_pkg::out_item_t  out_item,
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic                 cfg_index,
    input  logic [10:0]          cfg_data
);

    localparam int AW = (MAX_NODES > 1) ? $clog2(MAX_NODES) : 1;
    localparam int CW = AW + 1;
    localparam int DW = CW + 11;
    localparam logic [4:0] LAST_STEP = 5'(CW);

    typedef enum logic [11:0] {
        S_CLEAR = 12'b000000000001,
        S_IDLE  = 12'b000000000010,
        S_FRD   = 12'b000000000100,
        S_FCHK  = 12'b000000001000,
        S_CRD   = 12'b000000010000,
        S_CCHK  = 12'b000000100000,
        S_MRD   = 12'b000001000000,
        S_MWR   = 12'b000010000000,
        S_TRD   = 12'b000100000000,
        S_TMOD  = 12'b001000000000,
        S_TADD  = 12'b010000000000,
        S_OUT   = 12'b100000000000
    } state_t;

    state_t state_reg, state_next;

    logic [AW-1:0]  par_mem [MAX_NODES];
    logic [CW-1:0]  size_mem [MAX_NODES];
    logic [63:0]    wgt_mem [MAX_NODES];

    logic [10:0] node_count_reg, divisor_reg;
    logic [AW-1:0] cur_reg, root_reg, ra_reg, rb_reg, a_reg, b_reg;
    logic side_reg;
    logic [CW-1:0] idx_reg;
    logic [AW-1:0] rd_par;
    logic [CW-1:0] rd_size;
    logic [63:0]   rd_wgt;
    logic [CW-1:0] sa_reg;
    logic [63:0]   wa_reg;
    logic [31:0]   w_reg;
    logic [31:0]   last_reg;
    logic [63:0]   total_reg;
    logic [1:0]    status_reg;
    logic          is_total_reg;
    logic [CW-1:0] rem_reg;
    logic [4:0]    step_reg;
    logic          late_reg;

    logic [CW-1:0] live_n;
    assign live_n = (int'(node_count_reg) > MAX_NODES) ? CW'(MAX_NODES)
                  : CW'(node_count_reg);

    // Divisor aligned to the current bit of the restoring modulo.
    logic [DW-1:0] div_shift;
    assign div_shift = DW'(divisor_reg) << (LAST_STEP - step_reg);

    assign cfg_ready = (state_reg == S_IDLE) && !out_valid;
    assign in_stall = !((state_reg == S_IDLE) && !out_valid);

    // Memory port: one address per cycle, chosen by state.
    logic [AW-1:0] addr;
    logic we_par, we_sz;
    logic [AW-1:0] wd_par;
    logic [CW-1:0] wd_sz;
    logic [63:0]   wd_wgt;

    always_comb
    begin
        addr = cur_reg;
        we_par = 1'b0;
        we_sz = 1'b0;
        wd_par = cur_reg;
        wd_sz = CW'(1);
        wd_wgt = '0;
        case (state_reg)
            S_CLEAR: begin
                addr = idx_reg[AW-1:0];
                we_par = 1'b1;
                we_sz = 1'b1;
                wd_par = idx_reg[AW-1:0];
            end
            S_CCHK: begin
                we_par = (rd_par != root_reg) && (cur_reg != root_reg);
                wd_par = root_reg;
            end
            S_MRD: addr = ra_reg;
            S_MWR: begin
                case (step_reg)
                    5'd0: addr = rb_reg;
                    5'd2: begin
                        addr = ra_reg;
                        we_sz = 1'b1;
                        wd_sz = sa_reg;
                        wd_wgt = wa_reg;
                    end
                    5'd3: begin
                        addr = rb_reg;
                        we_par = 1'b1;
                        wd_par = ra_reg;
                    end
                    default: addr = ra_reg;
                endcase
            end
            S_TRD, S_TMOD, S_TADD: addr = idx_reg[AW-1:0];
            default: ;
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (we_par) par_mem[addr] <= wd_par;
        if (we_sz) begin
            size_mem[addr] <= wd_sz;
            wgt_mem[addr] <= wd_wgt;
        end
        rd_par <= par_mem[addr];
        rd_size <= size_mem[addr];
        rd_wgt <= wgt_mem[addr];
    end

    logic late_now;
    assign late_now = $signed(in_item.edge_weight) < $signed(last_reg);

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_CLEAR: if (idx_reg == CW'(MAX_NODES - 1)) state_next = S_IDLE;
            S_IDLE: if (in_valid && !in_stall) begin
                if (in_item.mode) state_next = (live_n == '0) ? S_CLEAR : S_TRD;
                else if ({1'b0, in_item.node_a} >= 11'(live_n)
                      || {1'b0, in_item.node_b} >= 11'(live_n)) state_next = S_OUT;
                else state_next = S_FRD;
            end
            S_FRD:  state_next = S_FCHK;
            S_FCHK: if (rd_par == cur_reg) state_next = S_CRD;
                    else state_next = S_FRD;
            S_CRD:  state_next = S_CCHK;
            S_CCHK: if (cur_reg == root_reg || rd_par == root_reg) begin
                        if (side_reg) state_next = (ra_reg == root_reg) ? S_OUT : S_MRD;
                        else state_next = S_FRD;
                    end else state_next = S_CRD;
            S_MRD:  state_next = S_MWR;
            S_MWR:  if (step_reg == 5'd3) state_next = S_OUT;
            S_TRD:  state_next = S_TMOD;
            S_TMOD: if (step_reg == LAST_STEP) state_next = S_TADD;
            S_TADD: state_next = (idx_reg + 1'b1 >= live_n) ? S_CLEAR : S_TRD;
            S_OUT:  state_next = S_IDLE;
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_CLEAR;
            idx_reg <= '0;
            out_valid <= 1'b0;
            is_total_reg <= 1'b0;
            node_count_reg <= 11'd1024;
            divisor_reg <= 11'd1;
            last_reg <= 32'h8000_0000;
        end
        else
        begin
            state_reg <= state_next;
            if (out_valid && !out_stall) out_valid <= 1'b0;
            if (cfg_valid && cfg_ready) begin
                if (cfg_index == ufsf_pkg::CFG_NODE_COUNT) node_count_reg <= cfg_data;
                else divisor_reg <= cfg_data;
            end
            case (state_reg)
                S_CLEAR: begin
                    idx_reg <= idx_reg + 1'b1;
                    if (idx_reg == CW'(MAX_NODES - 1)) begin
                        last_reg <= 32'h8000_0000;
                        if (is_total_reg) out_valid <= 1'b1;
                    end
                end
                S_IDLE: if (in_valid && !in_stall) begin
                    a_reg <= AW'(in_item.node_a);
                    b_reg <= AW'(in_item.node_b);
                    cur_reg <= AW'(in_item.node_a);
                    w_reg <= in_item.edge_weight;
                    late_reg <= late_now;
                    side_reg <= 1'b0;
                    is_total_reg <= in_item.mode;
                    total_reg <= '0;
                    idx_reg <= '0;
                    status_reg <= ufsf_pkg::ST_MERGED;
                    if (!in_item.mode && ({1'b0, in_item.node_a} >= 11'(live_n)
                        || {1'b0, in_item.node_b} >= 11'(live_n)))
                        status_reg <= ufsf_pkg::ST_RANGE;
                end
                S_FCHK: if (rd_par == cur_reg) begin
                    root_reg <= cur_reg;
                    cur_reg <= side_reg ? b_reg : a_reg;
                end else cur_reg <= rd_par;
                S_CCHK: if (cur_reg == root_reg || rd_par == root_reg) begin
                    if (!side_reg) begin
                        ra_reg <= root_reg;
                        side_reg <= 1'b1;
                        cur_reg <= b_reg;
                    end else begin
                        rb_reg <= root_reg;
                        if (ra_reg == root_reg)
                            status_reg <= late_reg ? ufsf_pkg::ST_LATE : ufsf_pkg::ST_SAME;
                        step_reg <= '0;
                    end
                end else cur_reg <= rd_par;
                S_MRD: ;
                S_MWR: begin
                    step_reg <= step_reg + 1'b1;
                    if (step_reg == 5'd0) begin
                        // Root a has been read; root b is read this cycle.
                        sa_reg <= rd_size;
                        wa_reg <= rd_wgt;
                    end
                    if (step_reg == 5'd1) begin
                        // Root b has been read: form the merged size and weight and
                        // keep the larger group as the surviving root.
                        sa_reg <= sa_reg + rd_size;
                        wa_reg <= wa_reg + rd_wgt + {{32{w_reg[31]}}, w_reg};
                        if (sa_reg < rd_size) begin
                            ra_reg <= rb_reg;
                            rb_reg <= ra_reg;
                        end
                        status_reg <= late_reg ? ufsf_pkg::ST_LATE : ufsf_pkg::ST_MERGED;
                    end
                end
                S_TRD: step_reg <= '0;
                S_TMOD: begin
                    if (step_reg == 5'd0) rem_reg <= rd_size;
                    else if (DW'(rem_reg) >= div_shift && divisor_reg != '0)
                        rem_reg <= rem_reg - div_shift[CW-1:0];
                    step_reg <= step_reg + 1'b1;
                end
                S_TADD: begin
                    if (rd_par == idx_reg[AW-1:0] && divisor_reg != '0 && rem_reg == '0)
                        total_reg <= total_reg + rd_wgt;
                    if (idx_reg + 1'b1 >= live_n) idx_reg <= '0;
                    else idx_reg <= idx_reg + 1'b1;
                end
                S_OUT: begin
                    out_valid <= 1'b1;
                    if (status_reg != ufsf_pkg::ST_RANGE) last_reg <= w_reg;
                end
                default: ;
            endcase
        end
    end

    // The merge step is split: step 0 reads root b, step 1 orders the pair and forms
    // the sums, step 2 writes the surviving root and step 3 links the smaller one.
    always_comb
    begin
        out_item.status = is_total_reg ? ufsf_pkg::ST_MERGED : status_reg;
        out_item.total_sum = is_total_reg ? total_reg : '0;
        out_item.is_total = is_total_reg;
    end

endmodule

// ===== hdl/ufsf_checker.sv =====
// Port-level checker for the union-find spanning forest block, with its bind.
module ufsf_checker (
    input logic clk,
    input logic rst_n,
    input logic in_stall,
    input logic out_valid,
    input logic out_stall,
    input ufsf_pkg::out_item_t out_item
);

    // A stalled result holds.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(out_item))
        else $error("stalled result changed");

    // An edge result never carries a total.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_item.is_total |-> out_item.total_sum == '0)
        else $error("edge result carries a total");

    // A finish result always reports the merged status code.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_item.is_total |-> out_item.status == ufsf_pkg::ST_MERGED)
        else $error("finish result status wrong");

    // No item is taken while a result waits.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> in_stall)
        else $error("input accepted while result pending");

endmodule

bind union_find_spanning_forest ufsf_checker u_ufsf_checker (
    .clk(clk), .rst_n(rst_n), .in_stall(in_stall),
    .out_valid(out_valid), .out_stall(out_stall), .out_item(out_item)
);

// ===== bench/tb_union_find_spanning_forest.sv =====
// Self-checking testbench for the union-find spanning forest engine.
`timescale 1ns / 100ps

module tb_union_find_spanning_forest;

    localparam int NODES = 1024;

    logic                clk;
    logic                rst_n;
    logic                in_valid;
    logic                in_stall;
    ufsf_pkg::in_item_t  in_item;
    logic                out_valid;
    logic                out_stall;
    ufsf_pkg::out_item_t out_item;
    logic                cfg_valid;
    logic                cfg_ready;
    logic                cfg_index;
    logic [10:0]         cfg_data;

    union_find_spanning_forest #(.MAX_NODES(NODES)) u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_item   (in_item),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_item  (out_item),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    // Shadow copy of the forest, kept in step with every accepted item.
    logic [9:0]         link_mem [NODES];
    logic [10:0]        size_mem [NODES];
    logic [63:0]        wsum_mem [NODES];
    logic signed [31:0] prev_weight;
    logic [10:0]        live_nodes;
    logic [10:0]        size_div;

    ufsf_pkg::out_item_t pending_results [$];
    int        mismatches;
    bit        hold_off_active;
    int        hold_off_cycles;

    always
    begin
        clk = 1'b1;
        #1;
        clk = 1'b0;
        #1;
    end

    function automatic int short_or_long_gap();
        int pick;
        pick = $urandom_range(0, 99);
        if (pick < 40)
            return 0;
        else if (pick < 92)
            return $urandom_range(1, 3);
        else
            return $urandom_range(10, 60);
    endfunction

    function automatic void wipe_forest();
        for (int i = 0; i < NODES; i++)
        begin
            link_mem[i] = i[9:0];
            size_mem[i] = 11'd1;
            wsum_mem[i] = 64'd0;
        end
        prev_weight = 32'sh8000_0000;
    endfunction

    // Find with path compression, matching the block's two-pass walk.
    function automatic logic [9:0] find_root(logic [9:0] node);
        logic [9:0] root;
        logic [9:0] nxt;
        root = node;
        while (link_mem[root] != root)
            root = link_mem[root];
        while (link_mem[node] != root)
        begin
            nxt = link_mem[node];
            link_mem[node] = root;
            node = nxt;
        end
        return root;
    endfunction

    // Applies one item to the shadow forest and returns the result it must give.
    function automatic ufsf_pkg::out_item_t forest_outcome(ufsf_pkg::in_item_t it);
        ufsf_pkg::out_item_t res;
        int         limit;
        logic [9:0] ra;
        logic [9:0] rb;
        logic [9:0] tmp;
        bit         late;
        res = '0;
        limit = (live_nodes > NODES) ? NODES : int'(live_nodes);
        if (it.mode)
        begin
            for (int i = 0; i < limit; i++)
                if (link_mem[i] == i[9:0] && size_div != 0 && size_mem[i] % size_div == 0)
                    res.total_sum = res.total_sum + wsum_mem[i];
            wipe_forest();
            res.is_total = 1'b1;
            res.status = ufsf_pkg::ST_MERGED;
        end
        else if (int'(it.node_a) >= limit || int'(it.node_b) >= limit)
        begin
            res.status = ufsf_pkg::ST_RANGE;
        end
        else
        begin
            late = it.edge_weight < prev_weight;
            ra = find_root(it.node_a);
            rb = find_root(it.node_b);
            if (ra == rb)
                res.status = ufsf_pkg::ST_SAME;
            else
            begin
                if (size_mem[ra] < size_mem[rb])
                begin
                    tmp = ra;
                    ra = rb;
                    rb = tmp;
                end
                link_mem[rb] = ra;
                size_mem[ra] = size_mem[ra] + size_mem[rb];
                wsum_mem[ra] = wsum_mem[ra] + 64'(it.edge_weight) + wsum_mem[rb];
                res.status = ufsf_pkg::ST_MERGED;
            end
            if (late)
                res.status = ufsf_pkg::ST_LATE;
            prev_weight = it.edge_weight;
        end
        return res;
    endfunction

    // Sends one item, with an optional random gap before it; the expectation is
    // queued at the edge where the block takes the item.
    task automatic send_item(ufsf_pkg::in_item_t it, bit with_gap);
        int gap;
        gap = with_gap ? short_or_long_gap() : 0;
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        in_item  <= it;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        pending_results.push_back(forest_outcome(it));
    endtask

    task automatic idle_input();
        in_valid <= 1'b0;
    endtask

    task automatic send_edge(int a, int b, int w, bit with_gap);
        ufsf_pkg::in_item_t it;
        it.mode        = 1'b0;
        it.node_a      = a[9:0];
        it.node_b      = b[9:0];
        it.edge_weight = w;
        send_item(it, with_gap);
    endtask

    task automatic send_finish(bit with_gap);
        ufsf_pkg::in_item_t it;
        it.mode        = 1'b1;
        it.node_a      = 10'($urandom);
        it.node_b      = 10'($urandom);
        it.edge_weight = $urandom;
        send_item(it, with_gap);
    endtask

    // Idles the input and waits until every expected result has arrived.
    task automatic drain_results();
        idle_input();
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    // Register writes only happen with nothing in flight.
    task automatic write_register(logic idx, int value);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value[10:0];
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        cfg_valid <= 1'b0;
        if (idx == ufsf_pkg::CFG_NODE_COUNT)
            live_nodes = value[10:0];
        else
            size_div = value[10:0];
        @(posedge clk);
    endtask

    // Random edges: mostly in range with slowly rising weights, some noise.
    task automatic random_case(int edges, int span, bit sorted);
        int w;
        int a;
        int b;
        w = -$urandom_range(0, 5000);
        for (int i = 0; i < edges; i++)
        begin
            if ($urandom_range(0, 19) == 0)
            begin
                a = $urandom_range(0, 1023);
                b = $urandom_range(0, 1023);
            end
            else
            begin
                a = $urandom_range(0, span - 1);
                b = $urandom_range(0, span - 1);
            end
            if (!sorted || $urandom_range(0, 9) == 0)
                w = $urandom;
            else
                w = w + $urandom_range(0, 1000);
            send_edge(a, b, w, 1'b1);
        end
        send_finish(1'b1);
    endtask

    task automatic test_directed_extremes();
        write_register(ufsf_pkg::CFG_NODE_COUNT, 1024);
        write_register(ufsf_pkg::CFG_DIVISOR, 1);
        send_edge(0, 1023, 32'sh8000_0000, 1'b0);
        send_edge(1023, 0, -5, 1'b0);
        send_edge(1, 2, 7, 1'b0);
        send_edge(2, 0, 7, 1'b0);
        send_edge(3, 4, 3, 1'b0);
        send_edge(5, 5, 32'sh7fff_ffff, 1'b0);
        send_edge(682, 341, 32'sh7fff_ffff, 1'b0);
        send_finish(1'b0);
        send_finish(1'b0);
        drain_results();
        // A small node count puts some endpoints out of range.
        write_register(ufsf_pkg::CFG_NODE_COUNT, 4);
        write_register(ufsf_pkg::CFG_DIVISOR, 2);
        send_edge(0, 1, 10, 1'b0);
        send_edge(3, 4, 11, 1'b0);
        send_edge(4, 0, 11, 1'b0);
        send_edge(2, 3, 12, 1'b0);
        send_edge(1, 3, 1, 1'b0);
        send_finish(1'b0);
        drain_results();
        // Zero nodes and a zero divisor.
        write_register(ufsf_pkg::CFG_NODE_COUNT, 0);
        write_register(ufsf_pkg::CFG_DIVISOR, 0);
        send_edge(0, 0, 1, 1'b0);
        send_finish(1'b0);
        drain_results();
        // Counts above the store size saturate; the node count changes mid-case.
        write_register(ufsf_pkg::CFG_NODE_COUNT, 2047);
        write_register(ufsf_pkg::CFG_DIVISOR, 2047);
        send_edge(1000, 1001, 1, 1'b0);
        drain_results();
        write_register(ufsf_pkg::CFG_NODE_COUNT, 1000);
        write_register(ufsf_pkg::CFG_DIVISOR, 1024);
        send_edge(999, 998, 2, 1'b0);
        send_finish(1'b0);
        drain_results();
    endtask

    // The receiver holds off while edges keep coming, so the block backs up.
    task automatic test_output_backpressure();
        write_register(ufsf_pkg::CFG_NODE_COUNT, 16);
        write_register(ufsf_pkg::CFG_DIVISOR, 1);
        hold_off_cycles = 300;
        hold_off_active = 1'b1;
        for (int i = 0; i < 12; i++)
            send_edge($urandom_range(0, 15), $urandom_range(0, 15), i, 1'b0);
        send_finish(1'b0);
        drain_results();
    endtask

    task automatic test_random_cases();
        int cnt;
        int span;
        for (int c = 0; c < 90; c++)
        begin
            cnt = (c % 15 == 0) ? 1024 : $urandom_range(2, 40);
            span = (cnt > 1000) ? 1024 : cnt;
            write_register(ufsf_pkg::CFG_NODE_COUNT, cnt);
            write_register(ufsf_pkg::CFG_DIVISOR,
                           $urandom_range(0, 5) == 0 ? $urandom_range(0, 2047)
                                                     : $urandom_range(1, 4));
            random_case($urandom_range(5, 30), span, $urandom_range(0, 3) != 0);
            drain_results();
        end
    endtask

    // Result checker: compares each accepted result with the oldest expectation.
    always @(posedge clk)
    begin
        ufsf_pkg::out_item_t want;
        if (rst_n && out_valid && !out_stall)
        begin
            if (pending_results.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result: status %0d total %0d is_total %0b",
                             out_item.status, out_item.total_sum, out_item.is_total);
            end
            else
            begin
                want = pending_results.pop_front();
                if (out_item.status !== want.status || out_item.total_sum !== want.total_sum
                    || out_item.is_total !== want.is_total)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("mismatch: expected %0d %0d %0b, got %0d %0d %0b",
                                 want.status, want.total_sum, want.is_total,
                                 out_item.status, out_item.total_sum, out_item.is_total);
                end
            end
        end
    end

    // Output stall: a counted long hold-off on request, otherwise random gaps.
    always @(posedge clk)
    begin
        int gap;
        if (!rst_n)
            out_stall <= 1'b0;
        else if (hold_off_active)
        begin
            out_stall <= 1'b1;
            hold_off_cycles--;
            if (hold_off_cycles <= 0)
                hold_off_active = 1'b0;
        end
        else
        begin
            gap = short_or_long_gap();
            out_stall <= (gap > 0 && $urandom_range(0, 2) == 0) ? 1'b1 : 1'b0;
        end
    end

    initial
    begin
        rst_n = 1'b0;
        in_valid = 1'b0;
        in_item = '0;
        cfg_valid = 1'b0;
        cfg_index = ufsf_pkg::CFG_NODE_COUNT;
        cfg_data = '0;
        mismatches = 0;
        hold_off_active = 1'b0;
        hold_off_cycles = 0;
        live_nodes = 11'd1024;
        size_div = 11'd1;
        wipe_forest();
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_directed_extremes();
        test_output_backpressure();
        test_random_cases();
        drain_results();
        if (mismatches == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

    initial
    begin
        #8000000;
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule

// ===== union_find_spanning_forest.f =====
hdl/ufsf_pkg.sv
hdl/union_find_spanning_forest.sv
hdl/ufsf_checker.sv
bench/tb_union_find_spanning_forest.sv
